[hdl/qsac_pkg.sv]
// ----------------------------------------------------------------------------
// qsac_pkg
// Shared types and constants for the quad separating-axis collision block.
// ----------------------------------------------------------------------------
package qsac_pkg;

    localparam int FIELD_W    = 16;
    localparam int DIST_W     = 25;
    localparam int LEN_FRAC   = 6;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic signed [FIELD_W-1:0] vertex_x;
        logic signed [FIELD_W-1:0] vertex_y;
        logic        [DIST_W-1:0]  distance_bound;
    } qsac_in_t;

    typedef struct packed {
        logic                      overlap;
        logic        [DIST_W-1:0]  best_distance;
        logic signed [FIELD_W-1:0] normal_x;
        logic signed [FIELD_W-1:0] normal_y;
        logic                      improved;
    } qsac_out_t;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } qsac_op_t;

    typedef struct packed {
        logic     start;
        qsac_op_t op;
    } qsac_iu_req_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_RD_P,
        S_RD_Q,
        S_DIFF,
        S_SQ_X,
        S_SQ_Y,
        S_CHK,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_DIVX_GO,
        S_DIVX_WAIT,
        S_DIVY_GO,
        S_DIVY_WAIT,
        S_PRJ_RD,
        S_PRJ_X,
        S_PRJ_Y,
        S_PRJ_UPD,
        S_CMP,
        S_GAP,
        S_DONE
    } qsac_state_t;

endpackage

[hdl/quad_separating_axis_collision.sv]
// ----------------------------------------------------------------------------
// quad_separating_axis_collision
// Separating-axis overlap test of two convex quads, one shared multiplier and
// one shared root/divide unit under a sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in        in   in_valid/in_stall  qsac_in_t: one vertex, bound on first
//  out       out  out_valid/out_stall qsac_out_t: one result per eight vertices
//
//  a vertex takes one cycle; the eighth starts a test of up to eight axes
//  each axis is bounded by the bit-serial root/divide unit, UW bits wide
//  (46 at defaults)
//  no vertex is taken while a test runs
//  a waiting result does not block loading of the next quads
//  reset clears control state only
// ----------------------------------------------------------------------------
module quad_separating_axis_collision
    import qsac_pkg::*;
#(
    parameter int COORD_BITS       = 16,
    parameter int NORMAL_FRAC_BITS = 15
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  qsac_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output qsac_out_t out_data
);

    localparam int CB    = COORD_BITS;
    localparam int NFB   = NORMAL_FRAC_BITS;
    localparam int NW    = NFB + 1;
    localparam int DXW   = CB + 1;
    localparam int SQW   = 2 * CB + 2;
    localparam int SW    = 2 * CB + 2 + 2 * LEN_FRAC;
    localparam int DW    = CB + NFB + 8;
    localparam int UWR   = (SW > DW) ? SW : DW;
    localparam int UW    = UWR + (UWR % 2);
    localparam int RW    = UW / 2;
    localparam int LW    = RW + 1;
    localparam int DVW   = RW + 2;
    localparam int REM_W = RW + 4;
    localparam int MA_W  = CB + 1;
    localparam int MB_W  = (CB + 1 > NW) ? CB + 1 : NW;
    localparam int PW    = MA_W + MB_W;
    localparam int PRW   = PW + 1;
    localparam int GW    = PRW + 1;
    localparam int GXW   = (GW + 1 > DIST_W + 1) ? GW + 1 : DIST_W + 1;
    localparam int SH    = NFB - 8;
    localparam logic [GXW-1:0] RND = (SH > 0) ? (GXW'(1) << ((SH > 0) ? SH - 1 : 0)) : '0;
    localparam logic [UW-1:0]  LIM = UW'(1) << NFB;

    qsac_state_t state_reg, state_next;

    logic [2:0]              cnt_reg;
    logic [2:0]              axis_reg;
    logic [2:0]              prj_reg;
    logic [DIST_W-1:0]       best_reg;
    logic signed [NW-1:0]    nx_reg, ny_reg;
    logic signed [NW-1:0]    nxc_reg, nyc_reg;
    logic                    imp_reg;
    logic                    ov_reg;
    logic signed [CB-1:0]    px_reg, py_reg;
    logic signed [DXW-1:0]   dx_reg, dy_reg;
    logic signed [PW-1:0]    prod_reg;
    logic [SQW-1:0]          s_reg;
    logic [LW-1:0]           len_reg;
    logic signed [PRW-1:0]   pr_reg;
    logic signed [PRW-1:0]   mn_reg [2];
    logic signed [PRW-1:0]   mx_reg [2];
    logic signed [GW-1:0]    g_reg;
    logic                    out_valid_reg;
    qsac_out_t               out_reg;

    logic                    in_acc;
    logic                    out_free;
    logic [2:0]              ram_raddr;
    logic [2*CB-1:0]         ram_rdata;
    logic [2*CB-1:0]         ram_wdata;
    logic [31:0]             fx_ext, fy_ext;
    logic signed [CB-1:0]    rx, ry;

    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [PW-1:0]    mul_p;

    qsac_iu_req_t            iu_req;
    logic [UW-1:0]           iu_opnd;
    logic [DVW-1:0]          iu_dvsr;
    logic                    iu_done;
    logic [UW-1:0]           iu_q;
    logic [REM_W-1:0]        iu_rem;

    logic [DXW-1:0]          mag;
    logic                    sat_neg;
    logic signed [NW-1:0]    nsat;
    logic                    sep;
    logic signed [GW-1:0]    ga, gb;
    logic [GXW-1:0]          gu;
    logic [DIST_W-1:0]       gq;
    logic [2:0]              q_idx;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign q_idx    = {axis_reg[2], axis_reg[1:0] + 2'd1};

    assign fx_ext    = 32'($unsigned(in_data.vertex_x));
    assign fy_ext    = 32'($unsigned(in_data.vertex_y));
    assign ram_wdata = {fx_ext[CB-1:0], fy_ext[CB-1:0]};
    assign rx        = ram_rdata[2*CB-1:CB];
    assign ry        = ram_rdata[CB-1:0];

    qsac_ram #(
        .WIDTH (2 * CB),
        .DEPTH (8)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (in_acc),
        .waddr (cnt_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    qsac_iter_unit #(
        .UW (UW)
    ) u_iter_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (iu_req),
        .opnd  (iu_opnd),
        .dvsr  (iu_dvsr),
        .done  (iu_done),
        .qr    (iu_q),
        .rem   (iu_rem)
    );

    assign mul_p = PW'(mul_a * mul_b);

    // normal saturation and rounding sign
    always_comb
    begin
        sat_neg = (state_reg == S_DIVX_WAIT) ? (dy_reg > 0) : (dx_reg < 0);
        if (sat_neg)
        begin
            if (iu_q > LIM)
            begin
                nsat = {1'b1, {NFB{1'b0}}};
            end
            else
            begin
                nsat = -$signed(iu_q[NW-1:0]);
            end
        end
        else
        begin
            if (iu_q >= LIM)
            begin
                nsat = {1'b0, {NFB{1'b1}}};
            end
            else
            begin
                nsat = $signed(iu_q[NW-1:0]);
            end
        end
    end

    // gap selection and conversion
    always_comb
    begin
        sep = !(mn_reg[0] <= mx_reg[1] && mx_reg[0] >= mn_reg[1]);
        ga  = GW'(mx_reg[1]) - GW'(mn_reg[0]);
        gb  = GW'(mx_reg[0]) - GW'(mn_reg[1]);
        gu  = (GXW'($unsigned(g_reg)) + RND) >> SH;
        gq  = (gu > GXW'(DIST_MAX)) ? DIST_MAX : gu[DIST_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:      if (in_acc && cnt_reg == 3'd7) state_next = S_RD_P;
            S_RD_P:      state_next = S_RD_Q;
            S_RD_Q:      state_next = S_DIFF;
            S_DIFF:      state_next = S_SQ_X;
            S_SQ_X:      state_next = S_SQ_Y;
            S_SQ_Y:      state_next = S_CHK;
            S_CHK:       state_next = (s_reg == '0) ? S_DONE : S_SQRT_GO;
            S_SQRT_GO:   state_next = S_SQRT_WAIT;
            S_SQRT_WAIT: if (iu_done) state_next = S_DIVX_GO;
            S_DIVX_GO:   state_next = S_DIVX_WAIT;
            S_DIVX_WAIT: if (iu_done) state_next = S_DIVY_GO;
            S_DIVY_GO:   state_next = S_DIVY_WAIT;
            S_DIVY_WAIT: if (iu_done) state_next = S_PRJ_RD;
            S_PRJ_RD:    state_next = S_PRJ_X;
            S_PRJ_X:     state_next = S_PRJ_Y;
            S_PRJ_Y:     state_next = S_PRJ_UPD;
            S_PRJ_UPD:   state_next = (prj_reg == 3'd7) ? S_CMP : S_PRJ_RD;
            S_CMP:       state_next = sep ? S_DONE : S_GAP;
            S_GAP:       state_next = (axis_reg == 3'd7) ? S_DONE : S_RD_P;
            S_DONE:      if (out_free) state_next = S_LOAD;
            default:     state_next = S_LOAD;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall     = (state_reg != S_LOAD);
        ram_raddr    = prj_reg;
        mul_a        = MA_W'(dx_reg);
        mul_b        = MB_W'(dx_reg);
        iu_req.start = 1'b0;
        iu_req.op    = OP_DIV;
        mag          = (dy_reg < 0) ? DXW'(-dy_reg) : DXW'(dy_reg);
        iu_opnd      = (UW'(mag) << (NFB + 7)) + UW'(len_reg);
        iu_dvsr      = {len_reg, 1'b0};
        unique case (state_reg)
            S_RD_P:
            begin
                ram_raddr = axis_reg;
            end
            S_RD_Q:
            begin
                ram_raddr = q_idx;
            end
            S_SQ_Y:
            begin
                mul_a = MA_W'(dy_reg);
                mul_b = MB_W'(dy_reg);
            end
            S_SQRT_GO:
            begin
                iu_req.start = 1'b1;
                iu_req.op    = OP_SQRT;
                iu_opnd      = UW'(s_reg) << (2 * LEN_FRAC);
            end
            S_DIVX_GO:
            begin
                iu_req.start = 1'b1;
            end
            S_DIVY_GO:
            begin
                iu_req.start = 1'b1;
                mag          = (dx_reg < 0) ? DXW'(-dx_reg) : DXW'(dx_reg);
                iu_opnd      = (UW'(mag) << (NFB + 7)) + UW'(len_reg);
            end
            S_PRJ_X:
            begin
                mul_a = MA_W'(rx);
                mul_b = MB_W'(nxc_reg);
            end
            S_PRJ_Y:
            begin
                mul_a = MA_W'(ry);
                mul_b = MB_W'(nyc_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            axis_reg      <= '0;
            prj_reg       <= '0;
            best_reg      <= '0;
            nx_reg        <= '0;
            ny_reg        <= '0;
            imp_reg       <= 1'b0;
            ov_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (cnt_reg == 3'd0)
                        begin
                            best_reg <= in_data.distance_bound;
                            nx_reg   <= '0;
                            ny_reg   <= '0;
                            imp_reg  <= 1'b0;
                        end
                        cnt_reg  <= cnt_reg + 3'd1;
                        axis_reg <= '0;
                    end
                end
                S_CHK:
                begin
                    ov_reg  <= 1'b0;
                    prj_reg <= '0;
                end
                S_PRJ_UPD:
                begin
                    prj_reg <= prj_reg + 3'd1;
                end
                S_CMP:
                begin
                    ov_reg <= 1'b0;
                end
                S_GAP:
                begin
                    if (gq <= best_reg)
                    begin
                        best_reg <= gq;
                        nx_reg   <= nxc_reg;
                        ny_reg   <= nyc_reg;
                        imp_reg  <= 1'b1;
                    end
                    axis_reg <= axis_reg + 3'd1;
                    ov_reg   <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_RD_Q:
            begin
                px_reg <= rx;
                py_reg <= ry;
            end
            S_DIFF:
            begin
                dx_reg <= DXW'(rx) - DXW'(px_reg);
                dy_reg <= DXW'(ry) - DXW'(py_reg);
            end
            S_SQ_X, S_PRJ_X:
            begin
                prod_reg <= mul_p;
            end
            S_SQ_Y:
            begin
                s_reg <= SQW'($unsigned(prod_reg) + $unsigned(mul_p));
            end
            S_SQRT_WAIT:
            begin
                if (iu_done)
                begin
                    len_reg <= LW'(iu_q[RW-1:0])
                             + LW'(iu_rem > REM_W'(iu_q[RW-1:0]));
                end
            end
            S_DIVX_WAIT:
            begin
                if (iu_done)
                begin
                    nxc_reg <= nsat;
                end
            end
            S_DIVY_WAIT:
            begin
                if (iu_done)
                begin
                    nyc_reg <= nsat;
                end
            end
            S_PRJ_Y:
            begin
                pr_reg <= PRW'(prod_reg) + PRW'(mul_p);
            end
            S_PRJ_UPD:
            begin
                if (prj_reg[1:0] == 2'd0 || pr_reg > mx_reg[prj_reg[2]])
                begin
                    mx_reg[prj_reg[2]] <= pr_reg;
                end
                if (prj_reg[1:0] == 2'd0 || pr_reg < mn_reg[prj_reg[2]])
                begin
                    mn_reg[prj_reg[2]] <= pr_reg;
                end
            end
            S_CMP:
            begin
                g_reg <= (ga <= gb) ? ga : gb;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_reg.overlap       <= ov_reg;
                    out_reg.best_distance <= best_reg;
                    out_reg.normal_x      <= FIELD_W'(32'(nx_reg));
                    out_reg.normal_y      <= FIELD_W'(32'(ny_reg));
                    out_reg.improved      <= imp_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_LOAD |-> cnt_reg == 3'd0)
        else $error("vertex count nonzero during test");

    a_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
        iu_done |-> (state_reg == S_SQRT_WAIT || state_reg == S_DIVX_WAIT
                     || state_reg == S_DIVY_WAIT))
        else $error("root/divide result outside a wait state");

    a_no_improve: assert property (@(posedge clk) disable iff (!rst_n)
        !imp_reg |-> (nx_reg == '0 && ny_reg == '0))
        else $error("normal set without improvement");

    a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD && $past(state_reg) != S_LOAD)
        |-> best_reg <= $past(best_reg))
        else $error("running best grew during test");

endmodule

[hdl/qsac_ram.sv]
// ----------------------------------------------------------------------------
// qsac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qsac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/qsac_iter_unit.sv]
// ----------------------------------------------------------------------------
// qsac_iter_unit
// Shared bit-serial unit: integer square root (two bits a cycle in, one root
// bit out) and restoring division (one quotient bit a cycle).
// ----------------------------------------------------------------------------
module qsac_iter_unit
    import qsac_pkg::*;
#(
    parameter int UW = 46
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qsac_iu_req_t         req,
    input  logic [UW-1:0]        opnd,
    input  logic [UW/2+1:0]      dvsr,
    output logic                 done,
    output logic [UW-1:0]        qr,
    output logic [UW/2+3:0]      rem
);

    localparam int RW    = UW / 2;
    localparam int DVW   = RW + 2;
    localparam int REM_W = RW + 4;
    localparam int CW    = $clog2(UW + 1);

    logic [UW-1:0]    opnd_reg, opnd_next;
    logic [UW-1:0]    qr_reg, qr_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [DVW-1:0]   dvsr_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    qsac_op_t         op_reg;

    logic [REM_W-1:0] remsh;
    logic [REM_W-1:0] trial;

    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            remsh = {rem_reg[REM_W-3:0], opnd_reg[UW-1:UW-2]};
            trial = REM_W'({qr_reg[RW-1:0], 2'b01});
        end
        else
        begin
            remsh = {rem_reg[REM_W-2:0], opnd_reg[UW-1]};
            trial = REM_W'(dvsr_reg);
        end
    end

    always_comb
    begin
        opnd_next = opnd_reg;
        qr_next   = qr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            opnd_next = opnd;
            qr_next   = '0;
            rem_next  = '0;
            cnt_next  = (req.op == OP_SQRT) ? CW'(RW) : CW'(UW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            opnd_next = (op_reg == OP_SQRT) ? (opnd_reg << 2) : (opnd_reg << 1);
            if (remsh >= trial)
            begin
                rem_next = remsh - trial;
                qr_next  = {qr_reg[UW-2:0], 1'b1};
            end
            else
            begin
                rem_next = remsh;
                qr_next  = {qr_reg[UW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        qr_reg   <= qr_next;
        rem_reg  <= rem_next;
        if (req.start)
        begin
            op_reg   <= req.op;
            dvsr_reg <= dvsr;
        end
    end

    assign done = done_reg;
    assign qr   = qr_reg;
    assign rem  = rem_reg;

endmodule

[bench/qsac_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qsac_checker
// Watches both channels of the quad collision block. It keeps its own copy of
// the vertex store and the running best, predicts each test result, and
// compares every output transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module qsac_checker
    import qsac_pkg::*;
#(
    parameter int COORD_BITS       = 16,
    parameter int NORMAL_FRAC_BITS = 15
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  qsac_in_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  qsac_out_t out_data,
    output int        fail_count,
    output int        pending
);

    longint          quad_x [8];
    longint          quad_y [8];
    logic [2:0]      vertex_idx;
    logic [DIST_W-1:0] best_gap;
    longint          best_nx;
    longint          best_ny;
    logic            gap_improved;
    qsac_out_t       collision_q [$];

    function automatic longint coord_of(logic [FIELD_W-1:0] raw);
        longint unsigned v;
        longint unsigned sb;
        v  = raw & ((64'd1 << COORD_BITS) - 1);
        sb = 64'd1 << (COORD_BITS - 1);
        return longint'(v) - longint'((v & sb) << 1);
    endfunction

    function automatic longint unsigned root_rounded(longint unsigned s);
        longint unsigned r;
        longint unsigned bitv;
        longint unsigned n;
        r    = 0;
        bitv = 64'd1 << 62;
        n    = s;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= r + bitv)
            begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        if (s - r * r > r)
            r++;
        return r;
    endfunction

    function automatic longint unit_comp(longint num, longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        longint lim;
        longint r;
        mag = longint'(num < 0 ? -num : num) << (NORMAL_FRAC_BITS + LEN_FRAC);
        q   = (2 * mag + len) / (2 * len);
        lim = 64'sd1 << NORMAL_FRAC_BITS;
        r   = num < 0 ? -longint'(q) : longint'(q);
        if (r > lim - 1)
            r = lim - 1;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] gap_q8(longint g);
        longint unsigned u;
        int sh;
        u  = g;
        sh = NORMAL_FRAC_BITS - 8;
        if (sh > 0)
            u = (u + (64'd1 << (sh - 1))) >> sh;
        return u > DIST_MAX ? DIST_MAX : u[DIST_W-1:0];
    endfunction

    // walks the eight axes; 0 on the first separating one or zero-length edge
    function automatic logic quads_overlap();
        int p;
        int q;
        longint dx;
        longint dy;
        longint unsigned s;
        longint unsigned len;
        longint nx;
        longint ny;
        longint pr;
        longint mn [2];
        longint mx [2];
        longint g;
        logic [DIST_W-1:0] gq;
        for (int axis = 0; axis < 8; axis++)
        begin
            p  = axis;
            q  = (axis & 4) | ((axis + 1) & 3);
            dx = quad_x[q] - quad_x[p];
            dy = quad_y[q] - quad_y[p];
            s  = dx * dx + dy * dy;
            if (s == 0)
                return 1'b0;
            len = root_rounded(s << (2 * LEN_FRAC));
            nx  = unit_comp(-dy, len);
            ny  = unit_comp(dx, len);
            for (int i = 0; i < 8; i++)
            begin
                pr = quad_x[i] * nx + quad_y[i] * ny;
                if ((i & 3) == 0 || pr > mx[i >> 2])
                    mx[i >> 2] = pr;
                if ((i & 3) == 0 || pr < mn[i >> 2])
                    mn[i >> 2] = pr;
            end
            if (!(mn[0] <= mx[1] && mx[0] >= mn[1]))
                return 1'b0;
            g  = (mx[1] - mn[0]) <= (mx[0] - mn[1]) ? mx[1] - mn[0] : mx[0] - mn[1];
            gq = gap_q8(g);
            if (gq <= best_gap)
            begin
                best_gap     = gq;
                best_nx      = nx;
                best_ny      = ny;
                gap_improved = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        qsac_out_t exp_res;
        qsac_out_t got;
        if (!rst_n)
        begin
            vertex_idx   <= '0;
            best_gap     = '0;
            best_nx      = 0;
            best_ny      = 0;
            gap_improved = 1'b0;
            collision_q.delete();
            fail_count   <= 0;
            pending      <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (vertex_idx == 0)
                begin
                    best_gap     = in_data.distance_bound;
                    best_nx      = 0;
                    best_ny      = 0;
                    gap_improved = 1'b0;
                end
                quad_x[vertex_idx] = coord_of(in_data.vertex_x);
                quad_y[vertex_idx] = coord_of(in_data.vertex_y);
                if (vertex_idx == 7)
                begin
                    exp_res.overlap       = quads_overlap();
                    exp_res.best_distance = best_gap;
                    exp_res.normal_x      = best_nx[FIELD_W-1:0];
                    exp_res.normal_y      = best_ny[FIELD_W-1:0];
                    exp_res.improved      = gap_improved;
                    collision_q.push_back(exp_res);
                end
                vertex_idx <= vertex_idx + 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                got = out_data;
                if (collision_q.size() == 0)
                begin
                    $error("result transaction with no prediction waiting");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_res = collision_q.pop_front();
                    if (got.overlap !== exp_res.overlap)
                        $error("overlap exp %0d got %0d", exp_res.overlap, got.overlap);
                    if (got.best_distance !== exp_res.best_distance)
                        $error("best_distance exp %0d got %0d",
                               exp_res.best_distance, got.best_distance);
                    if (got.normal_x !== exp_res.normal_x)
                        $error("normal_x exp %0d got %0d", exp_res.normal_x, got.normal_x);
                    if (got.normal_y !== exp_res.normal_y)
                        $error("normal_y exp %0d got %0d", exp_res.normal_y, got.normal_y);
                    if (got.improved !== exp_res.improved)
                        $error("improved exp %0d got %0d", exp_res.improved, got.improved);
                    if (got !== exp_res)
                        fail_count <= fail_count + 1;
                end
            end
            pending <= collision_q.size();
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the quad collision block: directed corner quads, then mostly
// well-formed nearby quad pairs with random content and some noise, under
// changing idle patterns on both channels. The checker does the comparison.
// ----------------------------------------------------------------------------
module tb;
    import qsac_pkg::*;

    localparam int TAIL_CYCLES = 2500;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    qsac_in_t  in_data;
    logic      out_valid;
    logic      out_stall = 1'b0;
    qsac_out_t out_data;
    int        fail_count;
    int        pending;
    int        send_idle_pct;
    int        recv_idle_pct;
    logic      hold_req;
    logic      hold_taken = 1'b0;

    quad_separating_axis_collision i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    qsac_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // receiver side, with a one-time long hold-off
    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            out_stall <= 1'b1;
            repeat (3000) @(posedge clk);
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_vertex(input int x, input int y, input logic [DIST_W-1:0] bound);
        in_valid                <= 1'b1;
        in_data.vertex_x        <= x[FIELD_W-1:0];
        in_data.vertex_y        <= y[FIELD_W-1:0];
        in_data.distance_bound  <= bound;
        do
            @(posedge clk);
        while (in_stall);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    function automatic int clip(int v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    task automatic send_quads(input int ax[4], input int ay[4], input int bx[4],
                              input int by[4], input logic [DIST_W-1:0] bound);
        for (int i = 0; i < 4; i++)
            send_vertex(ax[i], ay[i], i == 0 ? bound : DIST_W'($urandom));
        for (int i = 0; i < 4; i++)
            send_vertex(bx[i], by[i], DIST_W'($urandom));
    endtask

    task automatic make_quad(input int cx, input int cy, input int span,
                             output int qx[4], output int qy[4]);
        int a;
        int b;
        int j;
        a = $urandom_range(span, 1);
        b = $urandom_range(span, 1);
        j = span / 8 + 1;
        qx[0] = clip(cx - a + $urandom_range(j) - j / 2);
        qy[0] = clip(cy - b + $urandom_range(j) - j / 2);
        qx[1] = clip(cx + a + $urandom_range(j) - j / 2);
        qy[1] = clip(cy - b + $urandom_range(j) - j / 2);
        qx[2] = clip(cx + a + $urandom_range(j) - j / 2);
        qy[2] = clip(cy + b + $urandom_range(j) - j / 2);
        qx[3] = clip(cx - a + $urandom_range(j) - j / 2);
        qy[3] = clip(cy + b + $urandom_range(j) - j / 2);
    endtask

    task automatic random_test();
        int ax[4];
        int ay[4];
        int bx[4];
        int by[4];
        int cx;
        int cy;
        int span;
        logic [DIST_W-1:0] bound;
        span  = ($urandom_range(9) == 0) ? 16000 : $urandom_range(400, 2);
        cx    = int'($urandom_range(60000)) - 30000;
        cy    = int'($urandom_range(60000)) - 30000;
        bound = ($urandom_range(3) == 0) ? DIST_W'($urandom) : DIST_MAX;
        if ($urandom_range(7) == 0)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ax[i] = int'($urandom_range(65535)) - 32768;
                ay[i] = int'($urandom_range(65535)) - 32768;
                bx[i] = int'($urandom_range(65535)) - 32768;
                by[i] = int'($urandom_range(65535)) - 32768;
            end
        end
        else
        begin
            make_quad(cx, cy, span, ax, ay);
            make_quad(clip(cx + int'($urandom_range(2 * span)) - span),
                      clip(cy + int'($urandom_range(2 * span)) - span), span, bx, by);
            if ($urandom_range(15) == 0)
            begin
                bx[2] = bx[1];
                by[2] = by[1];
            end
        end
        send_quads(ax, ay, bx, by, bound);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        #8000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        hold_req      = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 83;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // overlapping 10-by-10 squares, bound at max then zero
        send_quads('{0, 10, 10, 0}, '{0, 0, 10, 10}, '{5, 15, 15, 5}, '{5, 5, 15, 15},
                   DIST_MAX);
        send_quads('{0, 10, 10, 0}, '{0, 0, 10, 10}, '{5, 15, 15, 5}, '{5, 5, 15, 15},
                   '0);
        // coordinate extremes
        send_quads('{-32768, 32767, 32767, -32768}, '{-32768, -32768, 32767, 32767},
                   '{-1, 1, 1, -1}, '{-1, -1, 1, 1}, DIST_MAX);
        // zero-length edge on B after overlapping A axes
        send_quads('{0, 100, 100, 0}, '{0, 0, 100, 100}, '{50, 150, 150, 150},
                   '{50, 50, 150, 150}, DIST_MAX);
        // separated quads
        send_quads('{0, 10, 10, 0}, '{0, 0, 10, 10}, '{100, 110, 110, 100},
                   '{0, 0, 10, 10}, DIST_MAX);

        for (int n = 0; n < 30; n++)
            random_test();
        drain();
        send_idle_pct = 83;
        recv_idle_pct = 33;
        hold_req <= 1'b1;
        for (int n = 0; n < 30; n++)
            random_test();
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 28; n++)
            random_test();
        drain();

        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
